// File: rtl/ppp_pkg.sv
// ----------------------------------------------------------------------------
// Perspective point projector package
// Shared widths, codes and lane payload types for the projector pipeline.
// ----------------------------------------------------------------------------
package ppp_pkg;

  localparam int CoordW     = 32;  // Q16.16 world coordinate
  localparam int VecW       = 16;  // Q1.14 vector component
  localparam int RelW       = CoordW + 1;
  localparam int ProdW      = RelW + VecW;
  localparam int DotW       = ProdW + 1;
  localparam int MagW       = DotW - 1;
  localparam int RatioFrac  = 24;
  localparam int RatioSteps = 47;  // quotient bits below the saturation value
  localparam int CapShift   = RatioSteps - RatioFrac;
  localparam int RatioW     = RatioSteps + 1;
  localparam int TanW       = 16;
  localparam int SizeW      = 16;
  localparam int ScaledW    = RatioW + SizeW;
  localparam int TermNumW   = ScaledW - 9;
  localparam int TermSteps  = 21;
  localparam int TermW      = TermSteps + 1;
  localparam int ScrW       = 20;
  localparam int SumW       = 24;
  localparam int CfgAddrW   = 3;
  localparam int CfgDataW   = 64;

  localparam logic signed [DotW-1:0] NearLimit = DotW'(1073742);
  localparam logic signed [SumW-1:0] ScrMax    = SumW'(524287);
  localparam logic signed [SumW-1:0] ScrMin    = -SumW'(524288);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_VIEW = 2'd1,
    ST_NEAR     = 2'd2
  } status_t;

  typedef enum logic [CfgAddrW-1:0] {
    REG_EYE_X    = 3'd0,
    REG_EYE_Y    = 3'd1,
    REG_EYE_Z    = 3'd2,
    REG_FORWARD  = 3'd3,
    REG_RIGHT    = 3'd4,
    REG_UP       = 3'd5,
    REG_FOV_TAN  = 3'd6,
    REG_VIEWPORT = 3'd7
  } cfg_reg_t;

  // Per-item flags carried beside the horizontal lane.
  typedef struct packed {
    status_t status;
    logic    neg;
    logic    sat;
  } lane_x_t;

  // Per-item flags carried beside the vertical lane.
  typedef struct packed {
    logic neg;
    logic sat;
  } lane_y_t;

endpackage

// File: rtl/ppp_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step: shifts in a numerator bit, subtracts the
// divisor where it fits and appends the quotient bit.
// ----------------------------------------------------------------------------
module ppp_div_cell #(
  parameter int RW = 16,
  parameter int NW = 16,
  parameter int QW = 16,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_valid,
  input  logic [RW-1:0] in_rem,
  input  logic [RW-1:0] in_div,
  input  logic [NW-1:0] in_num,
  input  logic [QW-1:0] in_quo,
  input  logic [PW-1:0] in_side,
  output logic          out_valid,
  output logic [RW-1:0] out_rem,
  output logic [RW-1:0] out_div,
  output logic [NW-1:0] out_num,
  output logic [QW-1:0] out_quo,
  output logic [PW-1:0] out_side
);

  logic          valid_r;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [RW-1:0] div_r;
  logic [NW-1:0] num_r;
  logic [QW-1:0] quo_r;
  logic [PW-1:0] side_r;
  logic [RW:0]   trial;
  logic [RW:0]   diff;
  logic          fits;

  always_comb begin
    trial   = {in_rem, in_num[NW-1]};
    diff    = trial - {1'b0, in_div};
    fits    = (trial >= {1'b0, in_div});
    rem_nxt = fits ? diff[RW-1:0] : trial[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r  <= rem_nxt;
      div_r  <= in_div;
      num_r  <= {in_num[NW-2:0], 1'b0};
      quo_r  <= {in_quo[QW-2:0], fits};
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_div   = div_r;
  assign out_num   = num_r;
  assign out_quo   = quo_r;
  assign out_side  = side_r;

endmodule

// File: rtl/ppp_div_chain.sv
// ----------------------------------------------------------------------------
// Divider chain
// A row of division cells, one quotient bit per cell, advancing together.
// ----------------------------------------------------------------------------
module ppp_div_chain #(
  parameter int STEPS = 16,
  parameter int RW    = 16,
  parameter int NW    = 16,
  parameter int PW    = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_valid,
  input  logic [RW-1:0]    in_rem,
  input  logic [RW-1:0]    in_div,
  input  logic [NW-1:0]    in_num,
  input  logic [PW-1:0]    in_side,
  output logic             out_valid,
  output logic [STEPS-1:0] out_quo,
  output logic [PW-1:0]    out_side
);

  logic             valid_w [STEPS+1];
  logic [RW-1:0]    rem_w   [STEPS+1];
  logic [RW-1:0]    div_w   [STEPS+1];
  logic [NW-1:0]    num_w   [STEPS+1];
  logic [STEPS-1:0] quo_w   [STEPS+1];
  logic [PW-1:0]    side_w  [STEPS+1];

  assign valid_w[0] = in_valid;
  assign rem_w[0]   = in_rem;
  assign div_w[0]   = in_div;
  assign num_w[0]   = in_num;
  assign quo_w[0]   = '0;
  assign side_w[0]  = in_side;

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    ppp_div_cell #(
      .RW (RW),
      .NW (NW),
      .QW (STEPS),
      .PW (PW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_valid  (valid_w[i]),
      .in_rem    (rem_w[i]),
      .in_div    (div_w[i]),
      .in_num    (num_w[i]),
      .in_quo    (quo_w[i]),
      .in_side   (side_w[i]),
      .out_valid (valid_w[i+1]),
      .out_rem   (rem_w[i+1]),
      .out_div   (div_w[i+1]),
      .out_num   (num_w[i+1]),
      .out_quo   (quo_w[i+1]),
      .out_side  (side_w[i+1])
    );
  end

  assign out_valid = valid_w[STEPS];
  assign out_quo   = quo_w[STEPS];
  assign out_side  = side_w[STEPS];

endmodule

// File: rtl/perspective_point_projector_unit.sv
// ----------------------------------------------------------------------------
// Perspective point projector
// Projects world points through a configured pinhole camera into a viewport.
// ----------------------------------------------------------------------------
// One word is taken every cycle while no result waits at the output. Each word
// passes the eye offset, product and dot-sum registers, a row of 47 division
// cells for the depth ratio, the register for the scale by the viewport size,
// a row of 21 division cells for the tangent divide and the output register.
// The whole pipeline holds while a result waits at the output.
// Registers may be written only while no word is in flight.
module perspective_point_projector_unit
  import ppp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [95:0]         in_tdata,   // point_x, point_y, point_z
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [39:0]         out_tdata,  // screen_x, screen_y
  output logic [1:0]          out_tuser   // status
);

  logic [CoordW-1:0] eye_r [3];
  logic [47:0]       vec_r [3];
  logic [31:0]       tan_r;
  logic [63:0]       box_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        eye_r[i] <= '0;
        vec_r[i] <= '0;
      end
      tan_r <= '0;
      box_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_EYE_X:    eye_r[0] <= cfg_wdata[CoordW-1:0];
        REG_EYE_Y:    eye_r[1] <= cfg_wdata[CoordW-1:0];
        REG_EYE_Z:    eye_r[2] <= cfg_wdata[CoordW-1:0];
        REG_FORWARD:  vec_r[0] <= cfg_wdata[47:0];
        REG_RIGHT:    vec_r[1] <= cfg_wdata[47:0];
        REG_UP:       vec_r[2] <= cfg_wdata[47:0];
        REG_FOV_TAN:  tan_r    <= cfg_wdata[31:0];
        REG_VIEWPORT: box_r    <= cfg_wdata;
      endcase
    end
  end

  logic [TanW-1:0]  tan_x, tan_y;
  logic [SizeW-1:0] size_x, size_y;
  logic [15:0]      org_x, org_y;
  logic             bad_view;

  assign tan_x    = tan_r[15:0];
  assign tan_y    = tan_r[31:16];
  assign org_x    = box_r[15:0];
  assign org_y    = box_r[31:16];
  assign size_x   = box_r[47:32];
  assign size_y   = box_r[63:48];
  assign bad_view = (size_x == '0) || (size_y == '0) || (tan_x == '0) || (tan_y == '0);

  logic adv;
  logic out_valid_r;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  // Eye offset.
  logic                   s1_valid_r;
  logic signed [RelW-1:0] rel_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        rel_r[i] <= $signed({in_tdata[CoordW*i+CoordW-1], in_tdata[CoordW*i +: CoordW]})
                  - $signed({eye_r[i][CoordW-1], eye_r[i]});
      end
    end
  end

  // Products: vector j, component i.
  logic                    s2_valid_r;
  logic signed [ProdW-1:0] prod_r [3][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          prod_r[j][i] <= rel_r[i] * $signed(vec_r[j][VecW*i +: VecW]);
        end
      end
    end
  end

  // Dot sums: depth, right, up.
  logic                   s3_valid_r;
  logic signed [DotW-1:0] dot_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        dot_r[j] <= DotW'(prod_r[j][0]) + DotW'(prod_r[j][1]) + DotW'(prod_r[j][2]);
      end
    end
  end

  // Set up the depth ratio divisions.
  logic [DotW-1:0] abs_x, abs_y;
  logic [MagW-1:0] mag_x, mag_y, depth;
  lane_x_t         rx_in;
  lane_y_t         ry_in;

  always_comb begin
    abs_x = dot_r[1][DotW-1] ? DotW'(-dot_r[1]) : DotW'(dot_r[1]);
    abs_y = dot_r[2][DotW-1] ? DotW'(-dot_r[2]) : DotW'(dot_r[2]);
    mag_x = abs_x[MagW-1:0];
    mag_y = abs_y[MagW-1:0];
    depth = dot_r[0][MagW-1:0];
    if (bad_view) begin
      rx_in.status = ST_BAD_VIEW;
    end else if (dot_r[0] <= NearLimit) begin
      rx_in.status = ST_NEAR;
    end else begin
      rx_in.status = ST_OK;
    end
    rx_in.neg = dot_r[1][DotW-1];
    // Screen y points down, so the vertical offset goes the other way.
    ry_in.neg = !dot_r[2][DotW-1];
    // A ratio of 2^CapShift or more pins the quotient at its saturation value.
    rx_in.sat = {{CapShift{1'b0}}, mag_x} >= {depth, {CapShift{1'b0}}};
    ry_in.sat = {{CapShift{1'b0}}, mag_y} >= {depth, {CapShift{1'b0}}};
  end

  logic                  rq_valid;
  logic [RatioSteps-1:0] rq_x, rq_y;
  lane_x_t               rx_out;
  lane_y_t               ry_out;

  ppp_div_chain #(
    .STEPS (RatioSteps),
    .RW    (MagW),
    .NW    (RatioSteps),
    .PW    ($bits(lane_x_t))
  ) u_ratio_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (s3_valid_r),
    .in_rem    (MagW'(mag_x[MagW-1:CapShift])),
    .in_div    (depth),
    .in_num    ({mag_x[CapShift-1:0], {RatioFrac{1'b0}}}),
    .in_side   (rx_in),
    .out_valid (rq_valid),
    .out_quo   (rq_x),
    .out_side  (rx_out)
  );

  ppp_div_chain #(
    .STEPS (RatioSteps),
    .RW    (MagW),
    .NW    (RatioSteps),
    .PW    ($bits(lane_y_t))
  ) u_ratio_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (s3_valid_r),
    .in_rem    (MagW'(mag_y[MagW-1:CapShift])),
    .in_div    (depth),
    .in_num    ({mag_y[CapShift-1:0], {RatioFrac{1'b0}}}),
    .in_side   (ry_in),
    .out_valid (),
    .out_quo   (rq_y),
    .out_side  (ry_out)
  );

  // Scale the ratio by the viewport size.
  logic [RatioW-1:0]  ratio_x, ratio_y;
  logic               sc_valid_r;
  logic [ScaledW-1:0] scaled_x_r, scaled_y_r;
  lane_x_t            sx_side_r;
  lane_y_t            sy_side_r;

  assign ratio_x = rx_out.sat ? {1'b1, {RatioSteps{1'b0}}} : {1'b0, rq_x};
  assign ratio_y = ry_out.sat ? {1'b1, {RatioSteps{1'b0}}} : {1'b0, rq_y};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_valid_r <= 1'b0;
    end else if (adv) begin
      sc_valid_r <= rq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      scaled_x_r <= ratio_x * size_x;
      scaled_y_r <= ratio_y * size_y;
      sx_side_r  <= rx_out;
      sy_side_r  <= ry_out;
    end
  end

  // Set up the tangent divisions with half-up rounding folded into the sum.
  logic [ScaledW-1:0]  rnd_x, rnd_y;
  logic [TermNumW-1:0] tn_x, tn_y;
  lane_x_t             tx_in;
  lane_y_t             ty_in;

  always_comb begin
    rnd_x      = scaled_x_r + {{(ScaledW-TanW-8){1'b0}}, tan_x, 8'd0};
    rnd_y      = scaled_y_r + {{(ScaledW-TanW-8){1'b0}}, tan_y, 8'd0};
    tn_x       = rnd_x[ScaledW-1:9];
    tn_y       = rnd_y[ScaledW-1:9];
    tx_in      = sx_side_r;
    ty_in      = sy_side_r;
    tx_in.sat  = tn_x >= {{(TermNumW-TanW-TermSteps){1'b0}}, tan_x, {TermSteps{1'b0}}};
    ty_in.sat  = tn_y >= {{(TermNumW-TanW-TermSteps){1'b0}}, tan_y, {TermSteps{1'b0}}};
  end

  logic                 tq_valid;
  logic [TermSteps-1:0] tq_x, tq_y;
  lane_x_t              tx_out;
  lane_y_t              ty_out;

  ppp_div_chain #(
    .STEPS (TermSteps),
    .RW    (TanW),
    .NW    (TermSteps),
    .PW    ($bits(lane_x_t))
  ) u_term_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (sc_valid_r),
    .in_rem    (tn_x[TermSteps +: TanW]),
    .in_div    (tan_x),
    .in_num    (tn_x[TermSteps-1:0]),
    .in_side   (tx_in),
    .out_valid (tq_valid),
    .out_quo   (tq_x),
    .out_side  (tx_out)
  );

  ppp_div_chain #(
    .STEPS (TermSteps),
    .RW    (TanW),
    .NW    (TermSteps),
    .PW    ($bits(lane_y_t))
  ) u_term_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (sc_valid_r),
    .in_rem    (tn_y[TermSteps +: TanW]),
    .in_div    (tan_y),
    .in_num    (tn_y[TermSteps-1:0]),
    .in_side   (ty_in),
    .out_valid (),
    .out_quo   (tq_y),
    .out_side  (ty_out)
  );

  // Place into the viewport and saturate. A capped term already saturates.
  logic [TermW-1:0]       term_x, term_y;
  logic signed [SumW-1:0] base_x, base_y, pos_x, pos_y;
  logic [ScrW-1:0]        scr_x, scr_y;

  always_comb begin
    term_x = tx_out.sat ? {1'b1, {TermSteps{1'b0}}} : {1'b0, tq_x};
    term_y = ty_out.sat ? {1'b1, {TermSteps{1'b0}}} : {1'b0, tq_y};
    base_x = $signed({{(SumW-20){org_x[15]}}, org_x, 4'd0})
           + $signed({{(SumW-SizeW-3){1'b0}}, size_x, 3'd0});
    base_y = $signed({{(SumW-20){org_y[15]}}, org_y, 4'd0})
           + $signed({{(SumW-SizeW-3){1'b0}}, size_y, 3'd0});
    pos_x  = tx_out.neg ? base_x - $signed(SumW'(term_x)) : base_x + $signed(SumW'(term_x));
    pos_y  = ty_out.neg ? base_y - $signed(SumW'(term_y)) : base_y + $signed(SumW'(term_y));
    if (pos_x > ScrMax) begin
      scr_x = ScrMax[ScrW-1:0];
    end else if (pos_x < ScrMin) begin
      scr_x = ScrMin[ScrW-1:0];
    end else begin
      scr_x = pos_x[ScrW-1:0];
    end
    if (pos_y > ScrMax) begin
      scr_y = ScrMax[ScrW-1:0];
    end else if (pos_y < ScrMin) begin
      scr_y = ScrMin[ScrW-1:0];
    end else begin
      scr_y = pos_y[ScrW-1:0];
    end
  end

  status_t         out_status_r;
  logic [ScrW-1:0] out_x_r, out_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= tq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_status_r <= tx_out.status;
      out_x_r      <= (tx_out.status == ST_OK) ? scr_x : '0;
      out_y_r      <= (tx_out.status == ST_OK) ? scr_y : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_y_r, out_x_r};
  assign out_tuser  = out_status_r;

endmodule
